@@ hdl/lshh_pkg.sv @@
// ----------------------------------------------------------------------------
// lshh_pkg
// Types and constants of the dot-product hash modulo the prime 2^32-5.
// ----------------------------------------------------------------------------
`default_nettype none

package lshh_pkg;

    localparam int VALUE_W  = 32;
    localparam int PROD_W   = 64;
    localparam int ACC_W    = 35;
    localparam int VLEN_W   = 7;
    localparam int MODD_W   = 31;
    localparam int CIDX_W   = 6;
    localparam int DIVC_W   = 6;

    localparam logic [ACC_W-1:0] HASH_PRIME = 35'd4294967291;

    localparam logic REQ_COEF = 1'b0;
    localparam logic REQ_COMP = 1'b1;

    localparam logic CFG_VECTOR_LENGTH = 1'b0;
    localparam logic CFG_MOD_DIVISOR   = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_FOLD = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

@@ hdl/lsh_product_mod_prime_hash.sv @@
// ----------------------------------------------------------------------------
// lsh_product_mod_prime_hash
// Hash bucket as a dot product of a coefficient table with vector components,
// folded modulo 2^32-5 and optionally reduced by a configurable modulus.
//
// Input channel (s_*): a transfer with s_req_type = coefficient writes
// s_value into table slot s_coef_index. A component transfer reads the
// coefficient at the running index from the table RAM, multiplies, adds
// and folds; s_ready returns once the fold state is through.
// The component that completes a vector also passes through the output state
// to hand the result to the output register, after the bit-serial remainder
// when mod_divisor is nonzero. The accumulate-fold loop runs through the RAM
// read port and the multiplier.
// Result channel (m_*): one output register; while it is held by a stalled
// receiver, input transfers that do not complete a vector go on, and the
// completing one waits until the register is free.
// Configuration: cfg_wr_en writes register cfg_index at once; write only
// while the block is idle. Reset sets vector_length to 1, mod_divisor to 0,
// clears the accumulator and the index; the table is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_product_mod_prime_hash #(
    parameter int MAX_VECTOR_LENGTH = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [lshh_pkg::MODD_W-1:0]       cfg_wr_data,

    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire logic                              s_req_type,
    input  wire logic [lshh_pkg::CIDX_W-1:0]       s_coef_index,
    input  wire logic [lshh_pkg::VALUE_W-1:0]      s_value,

    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic [lshh_pkg::VALUE_W-1:0]      m_hash_value
);

    localparam int LEN_W = $clog2(MAX_VECTOR_LENGTH + 1);
    localparam int CNT_W = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
    localparam int CMP_W = (LEN_W > lshh_pkg::VLEN_W) ? LEN_W : lshh_pkg::VLEN_W;
    localparam int IDX_W = (LEN_W > lshh_pkg::CIDX_W) ? LEN_W : lshh_pkg::CIDX_W;

    lshh_pkg::state_t state_reg, state_next;

    logic [lshh_pkg::VLEN_W-1:0]  vlen_reg;
    logic [lshh_pkg::MODD_W-1:0]  modd_reg;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [lshh_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]             slot_reg;
    logic                         last_reg;
    logic [lshh_pkg::VALUE_W-1:0] value_reg;
    logic [lshh_pkg::VALUE_W-1:0] rd_data_reg;
    logic [lshh_pkg::PROD_W-1:0]  prod_reg;
    logic [lshh_pkg::PROD_W-1:0]  sum_reg;
    logic [lshh_pkg::ACC_W-1:0]   result_reg;
    logic [lshh_pkg::VALUE_W-1:0] rem_reg;
    logic [lshh_pkg::DIVC_W-1:0]  divc_reg;
    logic                         m_valid_reg;
    logic [lshh_pkg::VALUE_W-1:0] m_hash_reg;

    logic [lshh_pkg::VALUE_W-1:0] coef_mem [0:MAX_VECTOR_LENGTH-1];

    logic                         in_xfer;
    logic                         comp_xfer;
    logic                         coef_we;
    logic [CMP_W-1:0]             vlen_ext;
    logic [LEN_W-1:0]             eff_len;
    logic [LEN_W-1:0]             len_m1;
    logic [CNT_W-1:0]             slot;
    logic                         slot_last;
    logic [lshh_pkg::ACC_W-1:0]   fold;
    logic [lshh_pkg::ACC_W-1:0]   fold_red;
    logic [lshh_pkg::VALUE_W-1:0] rem_shift;
    logic [lshh_pkg::VALUE_W-1:0] rem_trial;
    logic                         out_free;

    assign s_ready      = (state_reg == lshh_pkg::ST_IDLE);
    assign in_xfer      = s_valid && s_ready;
    assign comp_xfer    = in_xfer && (s_req_type == lshh_pkg::REQ_COMP);
    assign coef_we      = in_xfer && (s_req_type == lshh_pkg::REQ_COEF)
                          && (IDX_W'(s_coef_index) < IDX_W'(MAX_VECTOR_LENGTH));
    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;
    assign out_free     = !m_valid_reg || m_ready;

    // clamp the configured length to 1..MAX_VECTOR_LENGTH
    always_comb begin
        vlen_ext = CMP_W'(vlen_reg);
        if (vlen_ext == '0) begin
            eff_len = LEN_W'(1);
        end else if (vlen_ext > CMP_W'(MAX_VECTOR_LENGTH)) begin
            eff_len = LEN_W'(MAX_VECTOR_LENGTH);
        end else begin
            eff_len = LEN_W'(vlen_ext);
        end
        len_m1 = eff_len - LEN_W'(1);
        if (LEN_W'(cnt_reg) >= eff_len) begin
            slot = CNT_W'(len_m1);
        end else begin
            slot = cnt_reg;
        end
        slot_last = (LEN_W'(slot) == len_m1);
    end

    // fold low32 + 5*high32, subtract the prime once
    always_comb begin
        fold = lshh_pkg::ACC_W'(sum_reg[31:0])
             + lshh_pkg::ACC_W'(sum_reg[63:32])
             + lshh_pkg::ACC_W'({sum_reg[63:32], 2'b00});
        if (fold >= lshh_pkg::HASH_PRIME) begin
            fold_red = fold - lshh_pkg::HASH_PRIME;
        end else begin
            fold_red = fold;
        end
    end

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        rem_shift = {rem_reg[lshh_pkg::VALUE_W-2:0], result_reg[lshh_pkg::ACC_W-1]};
        if (rem_shift >= lshh_pkg::VALUE_W'(modd_reg)) begin
            rem_trial = rem_shift - lshh_pkg::VALUE_W'(modd_reg);
        end else begin
            rem_trial = rem_shift;
        end
    end

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            lshh_pkg::ST_IDLE: begin
                if (comp_xfer) begin
                    state_next = lshh_pkg::ST_MUL;
                end
            end
            lshh_pkg::ST_MUL: begin
                state_next = lshh_pkg::ST_ADD;
            end
            lshh_pkg::ST_ADD: begin
                state_next = lshh_pkg::ST_FOLD;
            end
            lshh_pkg::ST_FOLD: begin
                if (last_reg) begin
                    acc_next = '0;
                    cnt_next = '0;
                    if (modd_reg != '0) begin
                        state_next = lshh_pkg::ST_DIV;
                    end else begin
                        state_next = lshh_pkg::ST_OUT;
                    end
                end else begin
                    acc_next   = fold_red;
                    cnt_next   = slot_reg + CNT_W'(1);
                    state_next = lshh_pkg::ST_IDLE;
                end
            end
            lshh_pkg::ST_DIV: begin
                if (divc_reg == '0) begin
                    state_next = lshh_pkg::ST_OUT;
                end
            end
            lshh_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = lshh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lshh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lshh_pkg::ST_IDLE;
            vlen_reg    <= lshh_pkg::VLEN_W'(1);
            modd_reg    <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    lshh_pkg::CFG_VECTOR_LENGTH: vlen_reg <= cfg_wr_data[lshh_pkg::VLEN_W-1:0];
                    lshh_pkg::CFG_MOD_DIVISOR:   modd_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (state_reg == lshh_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (comp_xfer) begin
            slot_reg  <= slot;
            last_reg  <= slot_last;
            value_reg <= s_value;
        end
        if (state_reg == lshh_pkg::ST_MUL) begin
            prod_reg <= lshh_pkg::PROD_W'(rd_data_reg) * lshh_pkg::PROD_W'(value_reg);
        end
        if (state_reg == lshh_pkg::ST_ADD) begin
            sum_reg <= lshh_pkg::PROD_W'(acc_reg) + prod_reg;
        end
        if (state_reg == lshh_pkg::ST_FOLD) begin
            result_reg <= fold_red;
            rem_reg    <= '0;
            divc_reg   <= lshh_pkg::DIVC_W'(lshh_pkg::ACC_W - 1);
        end
        if (state_reg == lshh_pkg::ST_DIV) begin
            rem_reg    <= rem_trial;
            result_reg <= {result_reg[lshh_pkg::ACC_W-2:0], 1'b0};
            divc_reg   <= divc_reg - lshh_pkg::DIVC_W'(1);
        end
        if (state_reg == lshh_pkg::ST_OUT && out_free) begin
            if (modd_reg != '0) begin
                m_hash_reg <= rem_reg;
            end else begin
                m_hash_reg <= result_reg[lshh_pkg::VALUE_W-1:0];
            end
        end
    end

    // coefficient table RAM
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[CNT_W'(s_coef_index)] <= s_value;
        end
        if (comp_xfer) begin
            rd_data_reg <= coef_mem[slot];
        end
    end

    a_comp_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        comp_xfer |=> (state_reg == lshh_pkg::ST_MUL))
        else $error("component transfer did not start the multiply");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lshh_pkg::ST_OUT && m_valid && !m_ready)
        |=> (state_reg == lshh_pkg::ST_OUT))
        else $error("result overwrote a stalled output");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lshh_pkg::ST_DIV) |-> (rem_reg < lshh_pkg::VALUE_W'(modd_reg)))
        else $error("remainder out of range");

    a_clear_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lshh_pkg::ST_OUT) |-> (acc_reg == '0 && cnt_reg == '0))
        else $error("accumulator or index not cleared at vector end");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lshh_pkg::ST_DIV && divc_reg == '0) |=> (state_reg == lshh_pkg::ST_OUT))
        else $error("remainder did not finish");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dot-product hash modulo 2^32-5. Coefficient and
// component transfers are driven under random idling on both channels. A
// scoreboard predicts every hash bucket and checks the result stream in
// order, across several vector lengths and bucket moduli.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int TABLE_DEPTH  = 64;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam bit [63:0] PRIME_64 = 64'd4294967291;
    localparam bit [63:0] FOLD_MUL = 64'd5;

    class hash_scoreboard;
        bit [lshh_pkg::VALUE_W-1:0] coef_table [TABLE_DEPTH];
        bit                         coef_written [TABLE_DEPTH];
        bit [63:0]                  acc = '0;
        int unsigned                comp_count = 0;
        bit [lshh_pkg::VLEN_W-1:0]  vec_len = lshh_pkg::VLEN_W'(1);
        bit [lshh_pkg::MODD_W-1:0]  mod_div = '0;
        bit [lshh_pkg::VALUE_W-1:0] hash_queue [$];
        int                         errors = 0;

        function int unsigned used_length();
            if (vec_len == 0) return 1;
            if (vec_len > TABLE_DEPTH) return TABLE_DEPTH;
            return 32'(vec_len);
        endfunction

        function int unsigned next_slot();
            int unsigned len;
            len = used_length();
            return (comp_count >= len) ? len - 1 : comp_count;
        endfunction

        function void write_reg(logic idx, logic [lshh_pkg::MODD_W-1:0] data);
            if (idx == lshh_pkg::CFG_VECTOR_LENGTH) begin
                vec_len = data[lshh_pkg::VLEN_W-1:0];
            end else begin
                mod_div = data;
            end
        endfunction

        function void note_input(logic req, logic [lshh_pkg::CIDX_W-1:0] slot,
                                 logic [lshh_pkg::VALUE_W-1:0] val);
            int unsigned idx;
            bit [63:0]   sum;
            if (req == lshh_pkg::REQ_COEF) begin
                coef_table[slot]   = val;
                coef_written[slot] = 1'b1;
                return;
            end
            idx = next_slot();
            sum = acc + {32'd0, coef_table[idx]} * {32'd0, val};
            sum = {32'd0, sum[31:0]} + FOLD_MUL * {32'd0, sum[63:32]};
            if (sum >= PRIME_64) sum = sum - PRIME_64;
            acc = sum;
            if (idx + 1 >= used_length()) begin
                if (mod_div != 0) sum = sum % {33'd0, mod_div};
                hash_queue.push_back(sum[31:0]);
                acc        = '0;
                comp_count = 0;
            end else begin
                comp_count = idx + 1;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [lshh_pkg::VALUE_W-1:0] got);
            bit [lshh_pkg::VALUE_W-1:0] want;
            if (hash_queue.size() == 0) begin
                report($sformatf("hash_value %h with no transfer pending", got));
                return;
            end
            want = hash_queue.pop_front();
            if (got !== want) report($sformatf("hash_value %h, predicted %h", got, want));
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic                          cfg_index = lshh_pkg::CFG_VECTOR_LENGTH;
    logic [lshh_pkg::MODD_W-1:0]   cfg_wr_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_req_type = lshh_pkg::REQ_COEF;
    logic [lshh_pkg::CIDX_W-1:0]   s_coef_index = '0;
    logic [lshh_pkg::VALUE_W-1:0]  s_value = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [lshh_pkg::VALUE_W-1:0]  m_hash_value;

    bit                  quiet_phase = 1'b0;
    bit                  hold_req = 1'b0;
    hash_scoreboard      sb;

    lsh_product_mod_prime_hash uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_coef_index (s_coef_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [lshh_pkg::VALUE_W-1:0] random_word();
        case ($urandom_range(7, 0))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic req, logic [lshh_pkg::CIDX_W-1:0] slot,
                             logic [lshh_pkg::VALUE_W-1:0] val);
        int gap;
        if (!quiet_phase && $urandom_range(99, 0) < 10) begin
            gap = $urandom_range(4, 1);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_coef_index <= slot;
        s_value      <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(req, slot, val);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.hash_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic [lshh_pkg::VLEN_W-1:0] len,
                              logic [lshh_pkg::MODD_W-1:0] div);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= lshh_pkg::CFG_VECTOR_LENGTH;
        cfg_wr_data <= {{(lshh_pkg::MODD_W - lshh_pkg::VLEN_W){1'b0}}, len};
        @(posedge aclk);
        sb.write_reg(lshh_pkg::CFG_VECTOR_LENGTH,
                     {{(lshh_pkg::MODD_W - lshh_pkg::VLEN_W){1'b0}}, len});
        cfg_index   <= lshh_pkg::CFG_MOD_DIVISOR;
        cfg_wr_data <= div;
        @(posedge aclk);
        sb.write_reg(lshh_pkg::CFG_MOD_DIVISOR, div);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random(int n_items, int coef_pct);
        int unsigned slot;
        repeat (n_items) begin
            slot = sb.next_slot();
            if (!sb.coef_written[slot]) begin
                send_item(lshh_pkg::REQ_COEF, slot[lshh_pkg::CIDX_W-1:0], random_word());
            end else if ($urandom_range(99, 0) < coef_pct) begin
                send_item(lshh_pkg::REQ_COEF, lshh_pkg::CIDX_W'($urandom_range(63, 0)),
                          random_word());
            end else begin
                send_item(lshh_pkg::REQ_COMP, lshh_pkg::CIDX_W'($urandom_range(63, 0)),
                          random_word());
            end
        end
    endtask

    initial begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_hash_value);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (quiet_phase) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= 10);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("FAIL lsh_product_mod_prime_hash");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: one component per vector, raw hash
        send_item(lshh_pkg::REQ_COEF, 6'd0,  32'hFFFF_FFFF);
        send_item(lshh_pkg::REQ_COEF, 6'd63, 32'h0000_0000);
        send_item(lshh_pkg::REQ_COMP, 6'd63, 32'hFFFF_FFFF);
        send_item(lshh_pkg::REQ_COMP, 6'd0,  32'h0000_0000);
        send_item(lshh_pkg::REQ_COMP, 6'd21, 32'h0000_0001);
        wait_drained();

        // zero length acts as one, widest modulus
        set_config(7'd0, 31'h7FFF_FFFF);
        send_item(lshh_pkg::REQ_COMP, 6'd42, 32'hFFFF_FFFF);
        send_item(lshh_pkg::REQ_COEF, 6'd0,  32'h8000_0001);
        send_item(lshh_pkg::REQ_COMP, 6'd0,  32'hFFFF_FFFE);
        wait_drained();

        set_config(7'd3, 31'd1);
        send_item(lshh_pkg::REQ_COEF, 6'd1, 32'hFFFF_FFFF);
        send_item(lshh_pkg::REQ_COEF, 6'd2, 32'hFFFF_FFFF);
        send_item(lshh_pkg::REQ_COEF, 6'd0, 32'hFFFF_FFFF);
        send_item(lshh_pkg::REQ_COMP, 6'd0, 32'hFFFF_FFFF);
        send_item(lshh_pkg::REQ_COMP, 6'd0, 32'hFFFF_FFFF);
        send_item(lshh_pkg::REQ_COMP, 6'd0, 32'hFFFF_FFFF);
        send_item(lshh_pkg::REQ_COMP, 6'd5, 32'h1234_5678);
        send_item(lshh_pkg::REQ_COMP, 6'd5, 32'hFFFF_FFFF);
        wait_drained();

        // lower the length below the running index
        set_config(7'd1, 31'd0);
        send_item(lshh_pkg::REQ_COMP, 6'd9, 32'hDEAD_BEEF);
        send_item(lshh_pkg::REQ_COMP, 6'd9, 32'h0000_0003);
        wait_drained();

        // hold off the result side so the input stalls
        hold_req <= 1'b1;
        run_random(40, 20);
        wait_drained();

        set_config(7'd2, 31'h7FFF_FFFF);
        run_random(35, 20);
        wait_drained();

        quiet_phase <= 1'b1;
        set_config(7'd64, 31'd0);
        run_random(90, 5);
        wait_drained();

        quiet_phase <= 1'b0;
        set_config(7'd127, lshh_pkg::MODD_W'($urandom_range(32'h7FFF_FFFF, 1)));
        run_random(90, 5);
        wait_drained();

        set_config(lshh_pkg::VLEN_W'($urandom_range(8, 3)),
                   lshh_pkg::MODD_W'($urandom_range(32'h7FFF_FFFF, 1)));
        run_random(35, 20);
        wait_drained();

        set_config(7'd0, 31'd1);
        run_random(35, 20);
        wait_drained();

        set_config(lshh_pkg::VLEN_W'($urandom_range(8, 1)),
                   lshh_pkg::MODD_W'($urandom_range(1000, 2)));
        run_random(35, 20);
        wait_drained();

        set_config(7'd1, 31'h7FFF_FFFF);
        run_random(35, 20);
        wait_drained();

        if (sb.errors == 0) begin
            $display("PASS lsh_product_mod_prime_hash");
        end else begin
            $display("FAIL lsh_product_mod_prime_hash");
        end
        $finish;
    end

endmodule
